// ----- rtl/position_array_insert_delete_search_assert.svh -----
`ifndef POSITION_ARRAY_INSERT_DELETE_SEARCH_ASSERT_SVH
`define POSITION_ARRAY_INSERT_DELETE_SEARCH_ASSERT_SVH

// same-cycle implication
`define PAIDS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("position array check failed");

// next-cycle implication
`define PAIDS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("position array check failed");

`endif

// ----- rtl/paids_pkg.sv -----
`default_nettype none

package paids_pkg;

   localparam int CMD_W       = 3;
   localparam int POS_W       = 7;
   localparam int VAL_W       = 32;
   localparam int STAT_W      = 2;
   localparam int FOUND_W     = 7;
   localparam int CNT_OUT_W   = 8;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 56;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 3'd0,
      CMD_APPEND = 3'd1,
      CMD_INSERT = 3'd2,
      CMD_DELETE = 3'd3,
      CMD_SEARCH = 3'd4,
      CMD_READ   = 3'd5
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_RANGE    = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [CNT_OUT_W-1:0] entry_count;
      logic [VAL_W-1:0]     read_value;
      logic [FOUND_W-1:0]   found_index;
      status_type           status;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/position_array_insert_delete_search.sv -----
// dense array of signed 32-bit words with a live entry count
// requests enter on the req_ channel: clear, append, insert at a position,
// delete at a position, search for a key, or read an entry
// every request gives exactly one result on the rsp_ channel with status,
// the last matching index, the word read and the entry count afterwards
// one request is handled at a time; req_tready is high while the sequencer
// is idle, also while an earlier result still waits in the output register
// insert, delete and search move or compare one entry per cycle through the
// single-port-read memory, while clear, append, errors and unused codes do
// not walk the memory
// reset clears the entry count and the control state; memory contents are
// not cleared, since only entries below the count are ever read
// a stalled rsp_tready holds the result in the output register; the next
// request is then accepted and worked on, and its result waits until the
// output register is free
`default_nettype none

module position_array_insert_delete_search #(
   parameter int DEPTH = 128
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // cmd[2:0], position[9:3], value[41:10], zero fill
   input  wire logic [paids_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // status[1:0], found_index[8:2], read_value[40:9], entry_count[48:41], zero fill
   output logic      [paids_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int RSP_W = $bits(paids_pkg::rsp_type);

   logic                        res_valid;
   logic                        res_ready;
   paids_pkg::rsp_type          res;
   logic                        mem_we;
   logic [AW-1:0]               mem_waddr;
   logic [paids_pkg::VAL_W-1:0] mem_wdata;
   logic [AW-1:0]               mem_raddr;
   logic [paids_pkg::VAL_W-1:0] mem_rdata;

   logic                        rsp_valid_ff, rsp_valid_in;
   paids_pkg::rsp_type          rsp_ff, rsp_in;

   paids_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_cmd   (req_tdata[2:0]),
      .req_pos   (req_tdata[9:3]),
      .req_value (req_tdata[41:10]),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   paids_ram #(
      .WIDTH(paids_pkg::VAL_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // output register
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(paids_pkg::RSP_TDATA_W - RSP_W){1'b0}}, rsp_ff};

`include "position_array_insert_delete_search_assert.svh"

   `PAIDS_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)
   `PAIDS_ASSERT_NEXT(a_res_held, clock, reset, res_valid && !res_ready, res_valid)
   `PAIDS_ASSERT_SAME(a_count_bound, clock, reset, rsp_valid_ff, 32'(rsp_ff.entry_count) <= DEPTH)
   `PAIDS_ASSERT_SAME(a_miss_fields, clock, reset, rsp_valid_ff && rsp_ff.status == paids_pkg::ST_NOTFOUND, rsp_ff.found_index == '0 && rsp_ff.read_value == '0)

endmodule

`default_nettype wire

// ----- rtl/paids_ram.sv -----
`default_nettype none

module paids_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- rtl/paids_ctrl.sv -----
`default_nettype none

module paids_ctrl #(
   parameter int DEPTH = 128
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [paids_pkg::CMD_W-1:0]   req_cmd,
   input  wire logic [paids_pkg::POS_W-1:0]   req_pos,
   input  wire logic [paids_pkg::VAL_W-1:0]   req_value,
   output logic                               res_valid,
   input  wire logic                          res_ready,
   output paids_pkg::rsp_type                 res,
   output logic                               mem_we,
   output logic [$clog2(DEPTH)-1:0]           mem_waddr,
   output logic [paids_pkg::VAL_W-1:0]        mem_wdata,
   output logic [$clog2(DEPTH)-1:0]           mem_raddr,
   input  wire logic [paids_pkg::VAL_W-1:0]   mem_rdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > paids_pkg::POS_W) ? CW : paids_pkg::POS_W;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_WALK  = 5'b00010,
      S_DRAIN = 5'b00100,
      S_PUT   = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type                  state_ff, state_in;
   paids_pkg::cmd_type         op_ff, op_in;
   paids_pkg::status_type      status_ff, status_in;
   logic [AW-1:0]              pos_ff, pos_in;
   logic [paids_pkg::VAL_W-1:0] val_ff, val_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic [AW-1:0]              ptr_ff, ptr_in;
   logic [AW-1:0]              end_ff, end_in;
   logic                       pend_ff, pend_in;
   logic [AW-1:0]              pend_addr_ff, pend_addr_in;
   logic                       hit_ff, hit_in;
   logic [AW-1:0]              found_ff, found_in;
   logic [paids_pkg::VAL_W-1:0] rd_ff, rd_in;

   logic [XW-1:0] pos_x;
   logic [XW-1:0] cnt_x;
   logic          full;

   assign pos_x = XW'(req_pos);
   assign cnt_x = XW'(cnt_ff);
   assign full  = (cnt_ff == CW'(DEPTH));

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      status_in    = status_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      end_in       = end_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      hit_in       = hit_ff;
      found_in     = found_ff;
      rd_in        = rd_ff;

      // data read in the previous cycle
      if (pend_ff) begin
         if (op_ff == paids_pkg::CMD_SEARCH && mem_rdata == val_ff) begin
            hit_in   = 1'b1;
            found_in = pend_addr_ff;
         end
         if (op_ff == paids_pkg::CMD_READ) begin
            rd_in = mem_rdata;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = paids_pkg::cmd_type'(req_cmd);
               pos_in    = AW'(req_pos);
               val_in    = req_value;
               hit_in    = 1'b0;
               found_in  = '0;
               rd_in     = '0;
               status_in = paids_pkg::ST_OK;
               state_in  = S_DONE;
               unique case (paids_pkg::cmd_type'(req_cmd))
                  paids_pkg::CMD_CLEAR: begin
                     cnt_in = '0;
                  end
                  paids_pkg::CMD_APPEND: begin
                     if (full) begin
                        status_in = paids_pkg::ST_FULL;
                     end else begin
                        op_in    = paids_pkg::CMD_INSERT;
                        pos_in   = AW'(cnt_ff);
                        cnt_in   = cnt_ff + 1'b1;
                        state_in = S_PUT;
                     end
                  end
                  paids_pkg::CMD_INSERT: begin
                     if (full) begin
                        status_in = paids_pkg::ST_FULL;
                     end else if (pos_x > cnt_x) begin
                        status_in = paids_pkg::ST_RANGE;
                     end else begin
                        cnt_in = cnt_ff + 1'b1;
                        if (pos_x == cnt_x) begin
                           state_in = S_PUT;
                        end else begin
                           ptr_in   = AW'(cnt_ff - 1'b1);
                           end_in   = AW'(req_pos);
                           state_in = S_WALK;
                        end
                     end
                  end
                  paids_pkg::CMD_DELETE: begin
                     if (pos_x >= cnt_x) begin
                        status_in = paids_pkg::ST_RANGE;
                     end else begin
                        cnt_in = cnt_ff - 1'b1;
                        if (pos_x != cnt_x - XW'(1)) begin
                           ptr_in   = AW'(req_pos) + 1'b1;
                           end_in   = AW'(cnt_ff - 1'b1);
                           state_in = S_WALK;
                        end
                     end
                  end
                  paids_pkg::CMD_SEARCH: begin
                     if (cnt_ff == '0) begin
                        status_in = paids_pkg::ST_NOTFOUND;
                     end else begin
                        ptr_in   = '0;
                        end_in   = AW'(cnt_ff - 1'b1);
                        state_in = S_WALK;
                     end
                  end
                  paids_pkg::CMD_READ: begin
                     if (pos_x >= cnt_x) begin
                        status_in = paids_pkg::ST_RANGE;
                     end else begin
                        ptr_in   = AW'(req_pos);
                        end_in   = AW'(req_pos);
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WALK: begin
            pend_in = 1'b1;
            priority if (op_ff == paids_pkg::CMD_INSERT) begin
               pend_addr_in = ptr_ff + 1'b1;
            end else if (op_ff == paids_pkg::CMD_DELETE) begin
               pend_addr_in = ptr_ff - 1'b1;
            end else begin
               pend_addr_in = ptr_ff;
            end
            if (ptr_ff == end_ff) begin
               state_in = S_DRAIN;
            end else if (op_ff == paids_pkg::CMD_INSERT) begin
               ptr_in = ptr_ff - 1'b1;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            if (op_ff == paids_pkg::CMD_INSERT) begin
               state_in = S_PUT;
            end else begin
               state_in = S_DONE;
            end
            if (op_ff == paids_pkg::CMD_SEARCH && !hit_in) begin
               status_in = paids_pkg::ST_NOTFOUND;
            end
         end
         S_PUT: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      status_ff    <= status_in;
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      ptr_ff       <= ptr_in;
      end_ff       <= end_in;
      pend_addr_ff <= pend_addr_in;
      hit_ff       <= hit_in;
      found_ff     <= found_in;
      rd_ff        <= rd_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);

   assign res.status      = status_ff;
   assign res.found_index = paids_pkg::FOUND_W'(found_ff);
   assign res.read_value  = rd_ff;
   assign res.entry_count = paids_pkg::CNT_OUT_W'(cnt_ff);

   assign mem_raddr = ptr_ff;
   assign mem_we    = (state_ff == S_PUT) ||
                      (pend_ff && (op_ff == paids_pkg::CMD_INSERT ||
                                   op_ff == paids_pkg::CMD_DELETE));
   assign mem_waddr = (state_ff == S_PUT) ? pos_ff : pend_addr_ff;
   assign mem_wdata = (state_ff == S_PUT) ? val_ff : mem_rdata;

endmodule

`default_nettype wire

// ----- test/position_array_insert_delete_search_monitor.sv -----
`timescale 1ns / 100ps
`default_nettype none

module position_array_insert_delete_search_monitor #(
   parameter int DEPTH = 128
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   input  wire logic                                req_tready,
   // cmd[2:0], position[9:3], value[41:10], zero fill
   input  wire logic [paids_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  wire logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // status[1:0], found_index[8:2], read_value[40:9], entry_count[48:41], zero fill
   input  wire logic [paids_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output int unsigned                              fail_count,
   output int unsigned                              pending,
   output int unsigned                              stored_count,
   output int unsigned                              results_checked
);
   import paids_pkg::*;

   logic [VAL_W-1:0] words [DEPTH];
   int unsigned      fill;
   rsp_type          expected_outcomes [$];

   function automatic rsp_type array_outcome(input logic [CMD_W-1:0] cmd,
                                             input logic [POS_W-1:0] pos,
                                             input logic [VAL_W-1:0] val);
      rsp_type r;
      int      i;
      bit      hit;
      r = '0;
      r.status = ST_OK;
      hit = 1'b0;
      case (cmd)
         CMD_CLEAR: begin
            fill = 0;
         end
         CMD_APPEND: begin
            if (fill >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               words[fill] = val;
               fill++;
            end
         end
         CMD_INSERT: begin
            if (fill >= DEPTH) begin
               r.status = ST_FULL;
            end else if (pos > fill) begin
               r.status = ST_RANGE;
            end else begin
               for (i = fill; i > pos; i--) words[i] = words[i-1];
               words[pos] = val;
               fill++;
            end
         end
         CMD_DELETE: begin
            if (pos >= fill) begin
               r.status = ST_RANGE;
            end else begin
               for (i = pos; i + 1 < fill; i++) words[i] = words[i+1];
               fill--;
            end
         end
         CMD_SEARCH: begin
            for (i = 0; i < fill; i++) begin
               if (words[i] == val) begin
                  r.found_index = FOUND_W'(i);
                  hit = 1'b1;
               end
            end
            if (!hit) r.status = ST_NOTFOUND;
         end
         CMD_READ: begin
            if (pos >= fill) r.status = ST_RANGE;
            else r.read_value = words[pos];
         end
         default: begin
         end
      endcase
      r.entry_count = CNT_OUT_W'(fill);
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      if (reset) begin
         fill = 0;
         expected_outcomes.delete();
         fail_count = 0;
         results_checked = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata[$bits(rsp_type)-1:0]);
            if (expected_outcomes.size() == 0) begin
               fail_count++;
               $error("result with no request waiting: %h", rsp_tdata);
            end else begin
               want = expected_outcomes.pop_front();
               results_checked++;
               if (got.status !== want.status) begin
                  fail_count++;
                  $error("status expected %0d got %0d", want.status, got.status);
               end
               if (got.found_index !== want.found_index) begin
                  fail_count++;
                  $error("found_index expected %0d got %0d",
                         want.found_index, got.found_index);
               end
               if (got.read_value !== want.read_value) begin
                  fail_count++;
                  $error("read_value expected %h got %h",
                         want.read_value, got.read_value);
               end
               if (got.entry_count !== want.entry_count) begin
                  fail_count++;
                  $error("entry_count expected %0d got %0d",
                         want.entry_count, got.entry_count);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_outcomes.push_back(array_outcome(req_tdata[2:0], req_tdata[9:3],
                                                      req_tdata[41:10]));
         end
      end
      pending = expected_outcomes.size();
      stored_count = fill;
   end

endmodule

`default_nettype wire

// ----- test/position_array_insert_delete_search_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none

module position_array_insert_delete_search_tb;
   import paids_pkg::*;

   localparam int          DEPTH           = 128;
   localparam int          RANDOM_REQUESTS = 1525;
   localparam int          STEADY_FROM     = 1330;
   localparam int          HOLD_CYCLES     = 600;
   localparam int unsigned CYCLE_LIMIT     = 1_000_000;

   localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

   typedef enum int {MODE_FILL, MODE_GROW, MODE_SHRINK, MODE_CHURN} traffic_mode_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned stored_count;
   int unsigned results_checked;
   int unsigned sent;
   int unsigned peak_fill;
   int unsigned full_visits;
   int unsigned sent_per_cmd [8];
   bit          steady;
   bit          hold_done;

   position_array_insert_delete_search #(.DEPTH(DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   position_array_insert_delete_search_monitor #(.DEPTH(DEPTH)) array_monitor (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .fail_count      (fail_count),
      .pending         (pending),
      .stored_count    (stored_count),
      .results_checked (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [VAL_W-1:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3, 4, 5, 6: return VAL_W'($urandom_range(0, 11));
         default: return $urandom();
      endcase
   endfunction

   // mostly in range, sometimes anywhere
   function automatic logic [POS_W-1:0] pick_position(input int unsigned limit);
      if (limit == 0 || $urandom_range(0, 7) == 0) return POS_W'($urandom_range(0, 127));
      return POS_W'($urandom_range(0, limit - 1));
   endfunction

   function automatic logic [CMD_W-1:0] pick_command(input traffic_mode_type mode,
                                                     input int unsigned fill);
      int unsigned r;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_FILL: begin
            if (fill < DEPTH) return (r < 70) ? CMD_APPEND : CMD_INSERT;
            if (r < 25) return CMD_APPEND;
            if (r < 50) return CMD_INSERT;
            if (r < 65) return CMD_READ;
            if (r < 80) return CMD_SEARCH;
            return CMD_DELETE;
         end
         MODE_GROW: begin
            if (r < 30) return CMD_APPEND;
            if (r < 60) return CMD_INSERT;
            if (r < 70) return CMD_DELETE;
            if (r < 85) return CMD_SEARCH;
            return CMD_READ;
         end
         MODE_SHRINK: begin
            if (r < 45) return CMD_DELETE;
            if (r < 65) return CMD_SEARCH;
            if (r < 85) return CMD_READ;
            if (r < 90) return CMD_APPEND;
            if (r < 95) return CMD_INSERT;
            if (r < 97) return CMD_CLEAR;
            return CMD_UNUSED_LO;
         end
         default: begin
            if (r < 18) return CMD_APPEND;
            if (r < 36) return CMD_INSERT;
            if (r < 54) return CMD_DELETE;
            if (r < 72) return CMD_SEARCH;
            if (r < 90) return CMD_READ;
            if (r < 93) return CMD_CLEAR;
            if (r < 96) return CMD_UNUSED_LO;
            return CMD_UNUSED_HI;
         end
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                               input logic [VAL_W-1:0] val);
      int unsigned gap;
      if (!steady && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      if (stored_count > peak_fill) peak_fill = stored_count;
      if (stored_count == DEPTH) full_visits++;
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, val, pos, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      sent_per_cmd[cmd]++;
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      wait (pending == 0);
      @(negedge clock);
   endtask

   // result side
   initial begin
      int unsigned n;
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!hold_done && sent >= 60) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (!steady && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 17);
            rsp_tready <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end else if (!steady && $urandom_range(0, 15) == 0) begin
            rsp_tready <= 1'b1;
            repeat (49) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("position_array_insert_delete_search verification failed");
      $finish;
   end

   initial begin
      traffic_mode_type mode;
      int unsigned      idx;
      int unsigned      phase;
      int unsigned      length;
      int unsigned      k;
      int unsigned      limit;
      logic [CMD_W-1:0] cmd;
      logic [POS_W-1:0] pos;
      logic [VAL_W-1:0] val;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      steady = 1'b0;
      hold_done = 1'b0;
      sent = 0;
      peak_fill = 0;
      full_visits = 0;
      foreach (sent_per_cmd[i]) sent_per_cmd[i] = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty array, extremes, duplicates, ends of the array, unused codes
      send_request(CMD_SEARCH, 7'd0, 32'd5);
      send_request(CMD_READ, 7'd0, 32'd0);
      send_request(CMD_DELETE, 7'd0, 32'd0);
      send_request(CMD_INSERT, 7'd1, 32'd9);
      send_request(CMD_INSERT, 7'd0, 32'h8000_0000);
      send_request(CMD_APPEND, 7'd0, 32'h7fff_ffff);
      send_request(CMD_APPEND, 7'h7f, 32'hffff_ffff);
      send_request(CMD_INSERT, 7'd3, 32'd0);
      send_request(CMD_INSERT, 7'd1, 32'h7fff_ffff);
      send_request(CMD_SEARCH, 7'h7f, 32'h7fff_ffff);
      send_request(CMD_SEARCH, 7'd0, 32'h1234_5678);
      send_request(CMD_READ, 7'd4, 32'd0);
      send_request(CMD_READ, 7'd0, 32'hffff_ffff);
      send_request(CMD_READ, 7'd5, 32'd0);
      send_request(CMD_READ, 7'h7f, 32'd0);
      send_request(CMD_DELETE, 7'h7f, 32'd0);
      send_request(CMD_DELETE, 7'd0, 32'd0);
      send_request(CMD_DELETE, 7'd3, 32'd0);
      send_request(CMD_UNUSED_LO, 7'h7f, 32'hffff_ffff);
      send_request(CMD_UNUSED_HI, 7'h55, 32'h5555_aaaa);
      send_request(CMD_SEARCH, 7'd0, 32'hffff_ffff);
      send_request(CMD_CLEAR, 7'h7f, 32'hffff_ffff);
      send_request(CMD_READ, 7'd0, 32'd0);
      send_request(CMD_SEARCH, 7'd0, 32'd0);
      wait_for_drain();

      idx = 0;
      phase = 0;
      while (idx < RANDOM_REQUESTS) begin
         mode = (phase % 4 == 0) ? MODE_FILL : traffic_mode_type'($urandom_range(1, 3));
         length = (mode == MODE_FILL) ? 220 : $urandom_range(80, 200);
         if (phase % 3 == 2 && idx < STEADY_FROM) wait_for_drain();
         for (k = 0; k < length && idx < RANDOM_REQUESTS; k++) begin
            steady = (idx >= STEADY_FROM);
            cmd = pick_command(mode, stored_count);
            limit = (stored_count < DEPTH) ? stored_count + 1 : 0;
            case (cmd)
               CMD_INSERT: pos = pick_position(limit);
               CMD_DELETE, CMD_READ: pos = pick_position(stored_count);
               default: pos = POS_W'($urandom_range(0, 127));
            endcase
            case (cmd)
               CMD_APPEND, CMD_INSERT: val = pick_word();
               CMD_SEARCH: val = ($urandom_range(0, 9) < 7) ? pick_word() : $urandom();
               default: val = $urandom();
            endcase
            send_request(cmd, pos, val);
            idx++;
         end
         phase++;
      end

      req_tvalid <= 1'b0;
      wait (pending == 0);
      repeat (DEPTH + 20) @(posedge clock);
      $display("%0d requests: %0d clear, %0d append, %0d insert, %0d delete, %0d search, %0d read, %0d unused",
               sent, sent_per_cmd[CMD_CLEAR], sent_per_cmd[CMD_APPEND],
               sent_per_cmd[CMD_INSERT], sent_per_cmd[CMD_DELETE], sent_per_cmd[CMD_SEARCH],
               sent_per_cmd[CMD_READ], sent_per_cmd[CMD_UNUSED_LO] + sent_per_cmd[CMD_UNUSED_HI]);
      $display("%0d results compared, array filled up to %0d of %0d, %0d requests on a full array",
               results_checked, peak_fill, DEPTH, full_visits);
      if (fail_count == 0) begin
         $display("position_array_insert_delete_search verification clean");
      end else begin
         $display("position_array_insert_delete_search verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
